// File: rtl/batchnorm_backward_input_gradient_macros.svh
// assertion macros for the batch-norm input gradient block
`ifndef BATCHNORM_BACKWARD_INPUT_GRADIENT_MACROS_SVH
`define BATCHNORM_BACKWARD_INPUT_GRADIENT_MACROS_SVH
`ifndef SYNTHESIS
`define BNBIG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define BNBIG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BNBIG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BNBIG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/bnbig_pkg.sv
// shared types, constants and helpers of the batch-norm input gradient block
package bnbig_pkg;

  localparam int NW          = 13;
  localparam int IDX_W       = 12;
  localparam int DW          = 32;
  localparam int DIV_W       = 96;
  localparam int ACC_W       = 96;
  localparam int SQ_STEPS    = 32;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 48;
  localparam int MAX_ELEMENTS_DEF = 4096;
  localparam int FRAC_BITS_DEF    = 16;
  localparam logic [NW-1:0] EC_RESET = 13'd4096;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_RCP_START,
    OP_RCP_FIN,
    OP_L_MUL1,
    OP_L_SAT,
    OP_L_MUL2,
    OP_L_ACC,
    OP_D_RD,
    OP_D_MAG,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_ADD,
    OP_D_TERM,
    OP_D_T,
    OP_D_ABS,
    OP_D_DIV,
    OP_D_OUT
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_drain;
    logic idx_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

// File: rtl/bnbig_div.sv
// bit-serial restoring divider, wide dividend by 32-bit divisor, 33-bit quotient
module bnbig_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bnbig_pkg::DIV_W-1:0]  dividend,
  input  logic [31:0]                  divisor,
  output logic                         done,
  output logic [32:0]                  quo,
  output logic                         ovf
);
  import bnbig_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic             busy_r, done_r, ovf_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W-1:0] dvd_r;
  logic [31:0]      dsr_r, rem_r;
  logic [32:0]      quo_r;
  logic [32:0]      trial;
  logic             ge;

  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? 32'(trial - {1'b0, dsr_r}) : trial[31:0];
      // quotient bits above bit 32 only matter as an overflow mark
      ovf_r <= ovf_r | quo_r[32];
      quo_r <= {quo_r[31:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign ovf  = ovf_r;

endmodule

// File: rtl/bnbig_dp.sv
// datapath: element stores, sums, shared multiplier, square root and divider
module bnbig_dp #(
  parameter int MAX_ELEMENTS = bnbig_pkg::MAX_ELEMENTS_DEF,
  parameter int FRAC_BITS    = bnbig_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bnbig_pkg::dp_cmd_t                cmd,
  output bnbig_pkg::dp_stat_t               stat,
  input  logic [bnbig_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]                        in_tuser,
  input  logic                              cfg_wr_en,
  input  logic [bnbig_pkg::NW-1:0]          cfg_wr_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bnbig_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast,
  output logic [1:0]                        out_tuser
);
  import bnbig_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);

  // element stores
  logic [DW-1:0] sg_mem [MAX_ELEMENTS];
  logic [DW-1:0] xn_mem [MAX_ELEMENTS];

  logic [NW-1:0]    ec_r, n_eff, cnt_r;
  logic             in_mode_r;
  logic [IDX_W-1:0] in_idx_r;
  logic [DW-1:0]    in_grad_r, in_norm_r, in_gamma_r, in_var_r;
  logic [63:0]      sum1_r, sum2_r;
  logic [DW-1:0]    gamma_r, inv_r, sg_r, rd_sg_r, rd_xn_r;
  logic [63:0]      sq_x_r, sq_q_r, sq_bit_r, sq_trial;
  logic signed [65:0] mul_r, mul_sh;
  logic signed [32:0] ma, mb;
  logic             mul_en;
  logic [63:0]      opa_r, term_r, t_r;
  logic [31:0]      opb_r;
  logic             tneg_r, neg_r;
  logic [ACC_W-1:0] acc_r, acc_sh, tm_w;
  logic [AW-1:0]    addr;
  logic             div_start, div_done, div_ovf;
  logic [DIV_W-1:0] div_dvd;
  logic [31:0]      div_dsr;
  logic [32:0]      div_quo;
  logic [32:0]      lim;
  logic             res_sat;
  logic [31:0]      res;
  logic             out_valid_r, out_last_r, out_sat_r, out_nl_r;
  logic [DW-1:0]    out_grad_r;
  logic [IDX_W-1:0] out_idx_r;

  always_comb begin
    if (ec_r == '0) n_eff = NW'(1);
    else if (32'(ec_r) > MAX_ELEMENTS) n_eff = NW'(MAX_ELEMENTS);
    else n_eff = ec_r;
  end

  assign addr = AW'(in_idx_r);

  assign stat.in_range = NW'(in_idx_r) < n_eff;
  assign stat.is_drain = in_mode_r;
  assign stat.idx_zero = in_idx_r == '0;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r <= EC_RESET;
    end else if (cfg_wr_en) begin
      ec_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_mode_r  <= in_tuser[0];
      in_idx_r   <= in_tdata[11:0];
      in_grad_r  <= in_tdata[43:12];
      in_norm_r  <= in_tdata[75:44];
      in_gamma_r <= in_tdata[107:76];
      in_var_r   <= in_tdata[139:108];
    end
  end

  // shared 33x33 signed multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_L_MUL1: begin
        ma = {in_grad_r[31], in_grad_r};
        mb = {gamma_r[31], gamma_r};
      end
      OP_L_MUL2: begin
        ma = {sg_r[31], sg_r};
        mb = {in_norm_r[31], in_norm_r};
      end
      OP_MUL_LO: begin
        ma = {1'b0, opa_r[31:0]};
        mb = {1'b0, opb_r};
      end
      OP_MUL_HI: begin
        ma = {1'b0, opa_r[63:32]};
        mb = {1'b0, opb_r};
      end
      OP_D_TERM: begin
        ma = {{(33-NW){1'b0}}, n_eff};
        mb = {rd_sg_r[31], rd_sg_r};
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_sh   = mul_r >>> FRAC_BITS;
  assign sq_trial = sq_q_r + sq_bit_r;
  assign acc_sh   = acc_r >> FRAC_BITS;
  assign tm_w     = (acc_sh > ACC_W'(64'h4000_0000_0000_0000))
                    ? ACC_W'(64'h4000_0000_0000_0000) : acc_sh;

  always_ff @(posedge clk) begin
    if (mul_en) mul_r <= ma * mb;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SQ_INIT: begin
        sq_x_r   <= (64'(in_var_r) + 64'd1) << FRAC_BITS;
        sq_q_r   <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
      end
      OP_SQ_STEP: begin
        if (sq_x_r >= sq_trial) begin
          sq_x_r <= sq_x_r - sq_trial;
          sq_q_r <= (sq_q_r >> 1) + sq_bit_r;
        end else begin
          sq_q_r <= sq_q_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_L_SAT: begin
        if (mul_sh > 66'sh0_7FFF_FFFF) sg_r <= 32'h7FFF_FFFF;
        else if (mul_sh < -66'sh0_8000_0000) sg_r <= 32'h8000_0000;
        else sg_r <= mul_sh[31:0];
      end
      OP_D_RD: begin
        rd_sg_r <= sg_mem[addr];
        rd_xn_r <= xn_mem[addr];
      end
      OP_D_MAG: begin
        opa_r  <= mag64(sum2_r);
        opb_r  <= mag32(rd_xn_r);
        tneg_r <= sum2_r[63] ^ rd_xn_r[31];
      end
      OP_MUL_HI: acc_r <= ACC_W'(mul_r[63:0]);
      OP_MUL_ADD: acc_r <= acc_r + (ACC_W'(mul_r[63:0]) << 32);
      OP_D_TERM: term_r <= tneg_r ? (~tm_w[63:0] + 64'd1) : tm_w[63:0];
      OP_D_T: t_r <= mul_r[63:0] - sum1_r - term_r;
      OP_D_ABS: begin
        opa_r <= mag64(t_r);
        opb_r <= inv_r;
        neg_r <= t_r[63];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_L_ACC) begin
      sg_mem[addr] <= sg_r;
      xn_mem[addr] <= in_norm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum1_r  <= '0;
      sum2_r  <= '0;
      gamma_r <= '0;
      inv_r   <= '0;
      cnt_r   <= '0;
    end else begin
      case (cmd.op)
        OP_RCP_FIN: begin
          gamma_r <= in_gamma_r;
          inv_r   <= (div_ovf || div_quo[32]) ? 32'hFFFF_FFFF : div_quo[31:0];
          sum1_r  <= '0;
          sum2_r  <= '0;
          cnt_r   <= '0;
        end
        OP_L_ACC: begin
          sum1_r <= sum1_r + {{32{sg_r[31]}}, sg_r};
          sum2_r <= sum2_r + mul_sh[63:0];
          if (cnt_r != {NW{1'b1}}) cnt_r <= cnt_r + NW'(1);
        end
        default: ;
      endcase
    end
  end

  assign div_start = (cmd.op == OP_RCP_START) || (cmd.op == OP_D_DIV);
  assign div_dvd   = (cmd.op == OP_RCP_START) ? (DIV_W'(1) << (2 * FRAC_BITS)) : acc_sh;
  assign div_dsr   = (cmd.op == OP_RCP_START) ? sq_q_r[31:0] : 32'(n_eff);

  bnbig_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quo      (div_quo),
    .ovf      (div_ovf)
  );

  assign lim     = neg_r ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
  assign res_sat = div_ovf || (div_quo > lim);
  assign res     = res_sat ? (neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF)
                           : (neg_r ? (~div_quo[31:0] + 32'd1) : div_quo[31:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_D_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_D_OUT) begin
      out_grad_r <= res;
      out_idx_r  <= in_idx_r;
      out_last_r <= NW'(in_idx_r) == (n_eff - NW'(1));
      out_sat_r  <= res_sat;
      out_nl_r   <= cnt_r < n_eff;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_idx_r, out_grad_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_nl_r, out_sat_r};

endmodule

// File: rtl/bnbig_ctrl.sv
// controller: sequences load, reciprocal square root and drain steps
`include "batchnorm_backward_input_gradient_macros.svh"
module bnbig_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bnbig_pkg::dp_stat_t stat,
  output bnbig_pkg::dp_cmd_t  cmd
);
  import bnbig_pkg::*;

  localparam int SCW = $clog2(SQ_STEPS);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_SQ_INIT, S_SQ_STEP, S_RCP_START, S_RCP_WAIT, S_RCP_FIN,
    S_L_MUL1, S_L_SAT, S_L_MUL2, S_L_ACC,
    S_D_RD, S_D_MAG, S_D_M0, S_D_M1, S_D_M2, S_D_TERM, S_D_T, S_D_ABS,
    S_D_P0, S_D_P1, S_D_P2, S_D_DIV, S_D_WAIT, S_D_OUT
  } state_t;

  state_t         state_r, state_nxt;
  logic [SCW-1:0] sq_cnt_r, sq_cnt_nxt;

  assign in_tready   = state_r == S_IDLE;
  assign cmd.capture = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    sq_cnt_nxt = sq_cnt_r;
    cmd.op     = OP_NONE;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (!stat.in_range) state_nxt = S_IDLE;
        else if (stat.is_drain) state_nxt = S_D_RD;
        else if (stat.idx_zero) state_nxt = S_SQ_INIT;
        else state_nxt = S_L_MUL1;
      end
      S_SQ_INIT: begin
        cmd.op     = OP_SQ_INIT;
        sq_cnt_nxt = '0;
        state_nxt  = S_SQ_STEP;
      end
      S_SQ_STEP: begin
        cmd.op     = OP_SQ_STEP;
        sq_cnt_nxt = sq_cnt_r + SCW'(1);
        if (sq_cnt_r == SCW'(SQ_STEPS - 1)) state_nxt = S_RCP_START;
      end
      S_RCP_START: begin
        cmd.op    = OP_RCP_START;
        state_nxt = S_RCP_WAIT;
      end
      S_RCP_WAIT: if (stat.div_done) state_nxt = S_RCP_FIN;
      S_RCP_FIN: begin
        cmd.op    = OP_RCP_FIN;
        state_nxt = S_L_MUL1;
      end
      S_L_MUL1: begin
        cmd.op    = OP_L_MUL1;
        state_nxt = S_L_SAT;
      end
      S_L_SAT: begin
        cmd.op    = OP_L_SAT;
        state_nxt = S_L_MUL2;
      end
      S_L_MUL2: begin
        cmd.op    = OP_L_MUL2;
        state_nxt = S_L_ACC;
      end
      S_L_ACC: begin
        cmd.op    = OP_L_ACC;
        state_nxt = S_IDLE;
      end
      S_D_RD: begin
        cmd.op    = OP_D_RD;
        state_nxt = S_D_MAG;
      end
      S_D_MAG: begin
        cmd.op    = OP_D_MAG;
        state_nxt = S_D_M0;
      end
      S_D_M0: begin
        cmd.op    = OP_MUL_LO;
        state_nxt = S_D_M1;
      end
      S_D_M1: begin
        cmd.op    = OP_MUL_HI;
        state_nxt = S_D_M2;
      end
      S_D_M2: begin
        cmd.op    = OP_MUL_ADD;
        state_nxt = S_D_TERM;
      end
      S_D_TERM: begin
        cmd.op    = OP_D_TERM;
        state_nxt = S_D_T;
      end
      S_D_T: begin
        cmd.op    = OP_D_T;
        state_nxt = S_D_ABS;
      end
      S_D_ABS: begin
        cmd.op    = OP_D_ABS;
        state_nxt = S_D_P0;
      end
      S_D_P0: begin
        cmd.op    = OP_MUL_LO;
        state_nxt = S_D_P1;
      end
      S_D_P1: begin
        cmd.op    = OP_MUL_HI;
        state_nxt = S_D_P2;
      end
      S_D_P2: begin
        cmd.op    = OP_MUL_ADD;
        state_nxt = S_D_DIV;
      end
      S_D_DIV: begin
        cmd.op    = OP_D_DIV;
        state_nxt = S_D_WAIT;
      end
      S_D_WAIT: if (stat.div_done) state_nxt = S_D_OUT;
      S_D_OUT: begin
        // hold the result until the output word is free
        if (stat.out_free) begin
          cmd.op    = OP_D_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sq_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      sq_cnt_r <= sq_cnt_nxt;
    end
  end

  `BNBIG_ASSERT_NXT(a_accept_check, clk, rst_n, in_tvalid && in_tready, state_r == S_CHECK)
  `BNBIG_ASSERT_IMP(a_div_done_wait, clk, rst_n, stat.div_done, (state_r == S_RCP_WAIT) || (state_r == S_D_WAIT))
  `BNBIG_ASSERT_IMP(a_out_free, clk, rst_n, cmd.op == OP_D_OUT, stat.out_free)

endmodule

// File: rtl/batchnorm_backward_input_gradient.sv
// Batch-norm backward input gradient for one channel, signed fixed point.
// Input stream: tuser is mode (0 load, 1 drain), tdata holds element index,
// gradient, normalized output, gamma and variance. Loads produce no word; a
// drain of an in-range index produces one output word with gradient, index,
// tlast at the final index, and tuser flags for saturation and early drain.
// Items with an index at or beyond the element count are dropped.
// One item is worked at a time; in_tready is high only while the controller
// is idle. A load at index 0 first runs a 32-step square root and a 96-step
// divide for the reciprocal; a drain ends in a 96-step bit-serial divide by
// the count. The output word sits in a register: the next item is taken
// while it waits, and a drain result stalls only when that register is still
// occupied. Reset (synchronous, active low) clears sums, gamma, the
// reciprocal, the load count and sets the element count to 4096; the element
// stores are not cleared. The user must write the count register only while
// idle, through cfg_wr_en/cfg_wr_data; the block itself does not enforce this.
module batchnorm_backward_input_gradient #(
  parameter int MAX_ELEMENTS = bnbig_pkg::MAX_ELEMENTS_DEF,
  parameter int FRAC_BITS    = bnbig_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // element_index, grad_in, norm_in, gamma, variance, zero pad
  input  logic [bnbig_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic [0:0]                        in_tuser,
  input  logic                              cfg_wr_en,
  input  logic [bnbig_pkg::NW-1:0]          cfg_wr_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // grad_out, out_index, zero pad
  output logic [bnbig_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast,
  // saturated, not_loaded
  output logic [1:0]                        out_tuser
);
  import bnbig_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bnbig_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bnbig_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

// File: tb/batchnorm_backward_input_gradient_tb.sv
// self-checking testbench for the batch-norm input gradient block
module batchnorm_backward_input_gradient_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bnbig_pkg::*;

  localparam int MODE_LOAD  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 200;

  typedef struct {
    logic [31:0] grad;
    logic [11:0] idx;
    logic        last;
    logic        sat;
    logic        early;
  } grad_word_t;

  typedef struct {
    logic        mode;
    logic [11:0] idx;
    logic [31:0] g;
    logic [31:0] xn;
    logic [31:0] gam;
    logic [31:0] var_q;
    logic        typed;
    grad_word_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic cfg_wr_en = 1'b0;
  logic [NW-1:0] cfg_wr_data = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic [1:0] out_tuser;

  batchnorm_backward_input_gradient dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // channel state mirrored by the predictor
  logic [31:0] sg_mem [0:4095];
  logic [31:0] xn_mem [0:4095];
  bit          written [0:4095];
  logic [63:0] sum_sg, sum_sgxn;
  logic [31:0] gamma_q, inv_std;
  logic [12:0] loads_seen, elem_cfg;

  grad_word_t pending_grads[$];
  bit failed = 1'b0;
  bit quiet = 1'b0;
  int idle_cycles = 0;
  int items_sent = 0;

  function automatic logic [31:0] sqrt_floor(input logic [63:0] v);
    logic [63:0] r, probe, x;
    x = v;
    r = 0;
    probe = 64'h1 << 62;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= r + probe) begin
        x = x - (r + probe);
        r = (r >> 1) + probe;
      end else begin
        r = r >> 1;
      end
      probe = probe >> 2;
    end
    return r[31:0];
  endfunction

  function automatic int unsigned eff_n();
    if (elem_cfg == 0) return 1;
    if (elem_cfg > 4096) return 4096;
    return elem_cfg;
  endfunction

  // updates channel state; returns 1 with the gradient word a drain produces
  function automatic bit predict_grad(input logic mode, input logic [11:0] idx,
                                      input logic [31:0] g, input logic [31:0] xn,
                                      input logic [31:0] gam, input logic [31:0] var_q,
                                      output grad_word_t w);
    int unsigned n;
    logic [63:0] v, q64, sgx, s2m, mt, tm, t, term, lim;
    logic signed [63:0] prod, sh;
    logic [31:0] sg, xs, xm;
    logic [95:0] p;
    logic [79:0] ps, q;
    bit neg;
    n = eff_n();
    w = '{default: '0};
    if (idx >= n) return 0;
    if (mode == MODE_LOAD) begin
      if (idx == 0) begin
        v = {32'b0, var_q} + 64'd1;
        q64 = 64'h1_0000_0000 / {32'b0, sqrt_floor(v << 16)};
        gamma_q = gam;
        inv_std = (q64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q64[31:0];
        sum_sg = 0;
        sum_sgxn = 0;
        loads_seen = 0;
      end
      prod = $signed(g) * $signed(gamma_q);
      sh = prod >>> 16;
      if (sh > 64'sh7FFF_FFFF) sg = 32'h7FFF_FFFF;
      else if (sh < -64'sh8000_0000) sg = 32'h8000_0000;
      else sg = sh[31:0];
      sg_mem[idx] = sg;
      xn_mem[idx] = xn;
      written[idx] = 1'b1;
      sum_sg = sum_sg + {{32{sg[31]}}, sg};
      prod = $signed(sg) * $signed(xn);
      sum_sgxn = sum_sgxn + 64'(prod >>> 16);
      if (loads_seen < 13'd8191) loads_seen = loads_seen + 1;
      return 0;
    end
    sg = sg_mem[idx];
    xs = xn_mem[idx];
    sgx = {{32{sg[31]}}, sg};
    s2m = sum_sgxn[63] ? -sum_sgxn : sum_sgxn;
    xm = xs[31] ? -xs : xs;
    p = {32'b0, s2m} * {64'b0, xm};
    ps = p[95:16];
    tm = (ps > 80'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : ps[63:0];
    term = (sum_sgxn[63] != xs[31]) ? -tm : tm;
    t = 64'(n) * sgx - sum_sg - term;
    neg = t[63];
    mt = neg ? -t : t;
    p = {32'b0, mt} * {64'b0, inv_std};
    ps = p[95:16];
    q = ps / 80'(n);
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    w.sat = (q > 80'(lim));
    if (w.sat) w.grad = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else w.grad = neg ? -q[31:0] : q[31:0];
    w.idx = idx;
    w.last = (idx == n - 1);
    w.early = (loads_seen < n);
    return 1;
  endfunction

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom();
      default: return $urandom_range(0, 1) ? -$urandom_range(0, 32'h3_FFFF)
                                           : $urandom_range(0, 32'h3_FFFF);
    endcase
  endfunction

  task automatic send_word(input logic mode, input logic [11:0] idx, input logic [31:0] g,
                           input logic [31:0] xn, input logic [31:0] gam,
                           input logic [31:0] var_q, input bit typed, input grad_word_t want);
    int gap;
    grad_word_t w;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = mode;
    in_tdata = {4'b0, var_q, gam, xn, g, idx};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    if (predict_grad(mode, idx, g, xn, gam, var_q, w)) pending_grads.push_back(typed ? want : w);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_rand(input logic mode, input logic [11:0] idx);
    send_word(mode, idx, pick_data(), pick_data(),
              $urandom_range(0, 3) == 0 ? pick_data() : $urandom_range(32'h4000, 32'h2_0000),
              $urandom_range(0, 3) == 0 ? pick_data() : $urandom_range(0, 32'h4_0000),
              1'b0, '{default: '0});
  endtask

  // wait for the block to drain, then change the element count
  task automatic write_count(input logic [12:0] val);
    wait (pending_grads.size() == 0);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    elem_cfg = val;
  endtask

  function automatic logic [11:0] pick_written();
    int unsigned n, i;
    n = eff_n();
    for (int k = 0; k < 40; k++) begin
      i = $urandom_range(0, n - 1);
      if (written[i]) return i;
    end
    return 0;
  endfunction

  task automatic run_phase();
    int unsigned n, nl, nd;
    logic [12:0] cval;
    logic [11:0] order[$];
    case ($urandom_range(0, 19))
      0: cval = 0;
      1: cval = 1;
      2: cval = 8191;
      3: cval = 4096;
      4: cval = 4095;
      default: cval = $urandom_range(2, 24);
    endcase
    quiet = ($urandom_range(0, 3) == 0);
    write_count(cval);
    n = eff_n();
    nl = (n > 64) ? $urandom_range(8, 40) : n;
    send_rand(MODE_LOAD, 0);
    order = {};
    for (int i = 1; i < n; i++) order.push_back(i);
    order.shuffle();
    for (int i = 0; i < nl - 1 && i < order.size(); i++) begin
      if ($urandom_range(0, 9) == 0) send_rand(MODE_DRAIN, pick_written());
      if ($urandom_range(0, 14) == 0 && n < 4096)
        send_rand($urandom_range(0, 1), $urandom_range(n, 4095));
      if ($urandom_range(0, 14) == 0 && i > 0) send_rand(MODE_LOAD, order[0]);
      send_rand(MODE_LOAD, order[i]);
    end
    nd = $urandom_range(n > 32 ? 16 : n, n > 32 ? 40 : 2 * n);
    for (int i = 0; i < nd; i++) begin
      if ($urandom_range(0, 19) == 0 && n < 4096)
        send_rand(MODE_DRAIN, $urandom_range(n, 4095));
      else
        send_rand(MODE_DRAIN, pick_written());
    end
  endtask

  stim_row_t directed[] = '{
    '{MODE_LOAD,  12'd0,    32'h1,         32'h1,         32'h0,         32'h0,
      1'b0, '{default: '0}},
    '{MODE_DRAIN, 12'd0,    32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, '{32'h0, 12'd0, 1'b0, 1'b0, 1'b1}},
    '{MODE_LOAD,  12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
      1'b0, '{default: '0}},
    '{MODE_DRAIN, 12'd4095, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, '{32'h0, 12'd4095, 1'b1, 1'b0, 1'b1}},
    '{MODE_LOAD,  12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
      1'b0, '{default: '0}},
    '{MODE_LOAD,  12'd1, 32'h8000_0000, 32'h8000_0000, 32'h1234, 32'h0,
      1'b0, '{default: '0}},
    '{MODE_LOAD,  12'd2, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h0,
      1'b0, '{default: '0}},
    '{MODE_DRAIN, 12'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '{default: '0}},
    '{MODE_DRAIN, 12'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '{default: '0}},
    '{MODE_DRAIN, 12'd2, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '{default: '0}},
    '{MODE_LOAD,  12'd0, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF,
      1'b0, '{default: '0}},
    '{MODE_LOAD,  12'd1, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0,
      1'b0, '{default: '0}},
    '{MODE_LOAD,  12'd1, 32'h0002_0000, 32'h0000_8000, 32'h0, 32'h0,
      1'b0, '{default: '0}},
    '{MODE_DRAIN, 12'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '{default: '0}},
    '{MODE_DRAIN, 12'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '{default: '0}},
    '{MODE_LOAD,  12'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
      1'b0, '{default: '0}},
    '{MODE_LOAD,  12'd1, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'h0,
      1'b0, '{default: '0}},
    '{MODE_DRAIN, 12'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '{default: '0}}
  };

  // result side: random back-pressure
  int stall = 0;
  always @(negedge clk) begin
    if (stall > 0) begin
      out_tready <= 1'b0;
      stall <= stall - 1;
    end else begin
      out_tready <= 1'b1;
      stall <= gap_len();
    end
  end

  always @(posedge clk) begin
    grad_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_grads.size() == 0) begin
        $error("gradient word with none expected, index %0d", out_tdata[43:32]);
        failed = 1'b1;
      end else begin
        w = pending_grads.pop_front();
        if (out_tdata[31:0] !== w.grad) begin
          $error("grad_out expected %h got %h", w.grad, out_tdata[31:0]); failed = 1'b1;
        end
        if (out_tdata[43:32] !== w.idx) begin
          $error("out_index expected %0d got %0d", w.idx, out_tdata[43:32]); failed = 1'b1;
        end
        if (out_tlast !== w.last) begin
          $error("last expected %b got %b", w.last, out_tlast); failed = 1'b1;
        end
        if (out_tuser[0] !== w.sat) begin
          $error("saturated expected %b got %b", w.sat, out_tuser[0]); failed = 1'b1;
        end
        if (out_tuser[1] !== w.early) begin
          $error("not_loaded expected %b got %b", w.early, out_tuser[1]); failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    sum_sg = 0;
    sum_sgxn = 0;
    gamma_q = 0;
    inv_std = 0;
    loads_seen = 0;
    elem_cfg = 13'd4096;
    foreach (written[i]) written[i] = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    foreach (directed[i])
      send_word(directed[i].mode, directed[i].idx, directed[i].g, directed[i].xn,
                directed[i].gam, directed[i].var_q, directed[i].typed, directed[i].want);
    while (items_sent < 1800) run_phase();
    write_count(13'd3);
    run_phase();
    wait (pending_grads.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (!failed && pending_grads.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
